// ===== design/gpu_register_window_vblank_pacer_top_defines.svh =====
// Assertion macros used by the register window datapath.
`ifndef GPU_REGISTER_WINDOW_VBLANK_PACER_TOP_DEFINES_SVH
`define GPU_REGISTER_WINDOW_VBLANK_PACER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GRVP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("grvp assertion failed");
`define GRVP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("grvp assertion failed");
`else
`define GRVP_ASSERT(lbl, clk, rst, prop)
`define GRVP_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== design/grvp_pkg.sv =====
// Shared types, codes and constants of the register window and vblank pacer.
package grvp_pkg;

  localparam int IN_W   = 120;
  localparam int OUT_W  = 168;
  localparam int USER_W = 2;
  localparam int IDXW   = 14;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;

  localparam logic [IDXW-1:0] IDX_EDRAM_TIMING = 14'h0F00;
  localparam logic [IDXW-1:0] IDX_BC_CONTROL   = 14'h0F01;
  localparam logic [IDXW-1:0] IDX_FLIP_BASE    = 14'h1844;
  localparam logic [IDXW-1:0] IDX_RING_WPTR    = 14'h01C5;
  localparam logic [IDXW-1:0] IDX_SCANLINE     = 14'h194C;
  localparam logic [IDXW-1:0] IDX_INT_STATUS   = 14'h1951;
  localparam logic [IDXW-1:0] IDX_VIEWPORT     = 14'h1961;

  localparam logic [31:0] VAL_EDRAM_TIMING = 32'h0810_0748;
  localparam logic [31:0] VAL_BC_CONTROL   = 32'h0000_200E;
  localparam logic [15:0] DIM_LIMIT        = 16'h0FFF;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic exec;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    clr_last;
    logic    div_last;
    logic    out_free;
    action_t action;
  } dp_status_t;

  function automatic logic [11:0] sat_dim(input logic [15:0] v);
    return (v > DIM_LIMIT) ? DIM_LIMIT[11:0] : v[11:0];
  endfunction

endpackage

// ===== design/grvp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module grvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/grvp_divider.sv =====
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per step.
module grvp_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        step,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic [31:0] remainder,
  output logic        last
);

  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [33:0] trial;
  logic        ge;

  assign trial = {1'b0, rem, quo[63]} - {2'b00, dvs};
  assign ge    = ~trial[33];
  assign last  = (cnt == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (step) begin
      // remainder stays below the divisor, so its top bit is free on a shift
      rem <= ge ? trial[31:0] : {rem[30:0], quo[63]};
      quo <= {quo[62:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== design/grvp_datapath.sv =====
// Datapath: item registers, register store, pacer divider, counters, output register.
`include "gpu_register_window_vblank_pacer_top_defines.svh"
module grvp_datapath #(
  parameter int REGISTER_WORDS = 16384,
  parameter int MAX_CATCH_UP   = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  grvp_pkg::ctrl_cmd_t           cmd,
  output grvp_pkg::dp_status_t          sts,
  input  logic [grvp_pkg::IN_W-1:0]     s_tdata,
  input  logic [grvp_pkg::USER_W-1:0]   s_tuser,
  input  logic [15:0]                   panel_width,
  input  logic [15:0]                   panel_height,
  input  logic [31:0]                   tick_interval,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [grvp_pkg::OUT_W-1:0]    m_tdata
);
  import grvp_pkg::*;

  localparam int AW = $clog2(REGISTER_WORDS);
  localparam int CW = $clog2(MAX_CATCH_UP + 1);

  action_t         act;
  logic [IDXW-1:0] idx;
  logic [31:0]     wdata;
  logic [63:0]     now;
  logic            dev;

  logic [31:0] latched_front, flips_seen, kicks_seen, pulses_seen;
  logic [63:0] last_time;
  logic [31:0] front_next, flips_next, kicks_next, pulses_next;
  logic [63:0] last_next;

  logic [AW-1:0] clr_addr;
  logic          in_range;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic [63:0]   dividend;
  logic [31:0]   divisor;
  logic [63:0]   quotient;
  logic [31:0]   remainder;
  logic          div_last;
  logic [CW-1:0] capped;
  logic [CW-1:0] due;

  logic [31:0]      read_val;
  logic [2:0]       pulse_field;
  logic [OUT_W-1:0] out_reg;

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= action_t'(s_tuser);
      idx   <= s_tdata[15:2];
      wdata <= s_tdata[47:16];
      now   <= s_tdata[111:48];
      dev   <= s_tdata[112];
    end
  end

  // clearing pass over the register store
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign in_range  = ({1'b0, idx} < (IDXW + 1)'(REGISTER_WORDS));
  assign ram_we    = cmd.clr_en | (cmd.exec & (act == ACT_WRITE) & in_range);
  assign ram_waddr = cmd.clr_en ? clr_addr : idx[AW-1:0];
  assign ram_wdata = cmd.clr_en ? '0 : wdata;

  grvp_ram #(
    .WIDTH (32),
    .DEPTH (REGISTER_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // a backwards clock gives zero elapsed time
  assign dividend = (now < last_time) ? 64'd0 : now - last_time;
  assign divisor  = (tick_interval == 32'd0) ? 32'd1 : tick_interval;

  grvp_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.exec & (act == ACT_SAMPLE)),
    .step      (cmd.div_step),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder),
    .last      (div_last)
  );

  assign capped = (quotient > 64'(MAX_CATCH_UP)) ? CW'(MAX_CATCH_UP) : quotient[CW-1:0];
  assign due    = dev ? capped : '0;

  always_comb begin
    unique case (idx)
      IDX_EDRAM_TIMING: read_val = VAL_EDRAM_TIMING;
      IDX_BC_CONTROL:   read_val = VAL_BC_CONTROL;
      IDX_SCANLINE:     read_val = {20'd0, sat_dim(panel_height)};
      IDX_INT_STATUS:   read_val = 32'd1;
      IDX_VIEWPORT:     read_val = {4'd0, sat_dim(panel_width),
                                    4'd0, sat_dim(panel_height)};
      default:          read_val = in_range ? ram_rdata : 32'd0;
    endcase
  end

  always_comb begin
    front_next  = latched_front;
    flips_next  = flips_seen;
    kicks_next  = kicks_seen;
    pulses_next = pulses_seen;
    last_next   = last_time;
    pulse_field = 3'd0;
    case (act)
      ACT_WRITE: begin
        if (idx == IDX_FLIP_BASE) begin
          front_next = wdata;
          flips_next = flips_seen + 32'd1;
        end else if (idx == IDX_RING_WPTR) begin
          kicks_next = kicks_seen + 32'd1;
        end
      end
      ACT_SAMPLE: begin
        // every whole interval is consumed, capped or not
        last_next   = now - {32'd0, remainder};
        pulses_next = pulses_seen + 32'(due);
        pulse_field = 3'(due);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_front <= '0;
      flips_seen    <= '0;
      kicks_seen    <= '0;
      pulses_seen   <= '0;
      last_time     <= '0;
    end else if (cmd.commit) begin
      latched_front <= front_next;
      flips_seen    <= flips_next;
      kicks_seen    <= kicks_next;
      pulses_seen   <= pulses_next;
      last_time     <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_reg <= {5'd0, pulses_next, kicks_next, flips_next, front_next, pulse_field,
                  (act == ACT_READ) ? read_val : 32'd0};
    end
  end

  assign m_tdata = out_reg;

  assign sts.clr_last = (clr_addr == AW'(REGISTER_WORDS - 1));
  assign sts.div_last = div_last;
  assign sts.out_free = ~m_tvalid | m_tready;
  assign sts.action   = act;

  `GRVP_ASSERT(a_cmd_onehot, clk, rst, $onehot0({cmd.clr_en, cmd.load, cmd.exec, cmd.div_step, cmd.commit}))
  `GRVP_ASSERT(a_commit_slot, clk, rst, cmd.commit |-> (!m_tvalid || m_tready))
  `GRVP_ASSERT(a_commit_shows, clk, rst, cmd.commit |=> m_tvalid)
  `GRVP_ASSERT(a_step_sample, clk, rst, cmd.div_step |-> (act == ACT_SAMPLE))

endmodule

// ===== design/grvp_controller.sv =====
// Controller: sequences the clearing pass, item execution, division and commit.
module grvp_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output grvp_pkg::ctrl_cmd_t   cmd,
  input  grvp_pkg::dp_status_t  sts
);
  import grvp_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = (sts.action == ACT_SAMPLE) ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/gpu_register_window_vblank_pacer_top.sv =====
// Top level: configuration registers, controller and datapath of the register window.
//
//  channel  dir  handshake                  payload
//  s_*      in   s_tvalid / s_tready        s_tuser action, s_tdata item fields
//  m_*      out  m_tvalid / m_tready        m_tdata result fields
//  apb      in   psel, penable, pready      paddr, pwrite, pwdata, prdata
//
// Read, write and unused items pass through accept, execute and commit steps.
// A time sample divides between execute and commit: 64 radix-2 steps, one quotient bit each.
// After reset the register store is zeroed by a pass over all REGISTER_WORDS words; s_tready stays
// low meanwhile, configuration writes are still taken.
// A new item is accepted while the previous result waits in the output register; a stalled
// m_tready holds the next item in its commit step.
module gpu_register_window_vblank_pacer_top #(
  parameter int REGISTER_WORDS = 16384,
  parameter int MAX_CATCH_UP   = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [15:0] address, [47:16] write_data, [111:48] now_ticks, [112] device_ready
  input  logic [grvp_pkg::IN_W-1:0]     s_tdata,
  // [1:0] action
  input  logic [grvp_pkg::USER_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] read_data, [34:32] vblank_pulses, [66:35] flip_base, [98:67] flip_count,
  // [130:99] ring_kick_count, [162:131] vblank_total
  output logic [grvp_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import grvp_pkg::*;

  logic [15:0] panel_width;
  logic [15:0] panel_height;
  logic [31:0] tick_interval;
  logic        cfg_wr;
  ctrl_cmd_t   cmd;
  dp_status_t  sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width   <= 16'd1280;
      panel_height  <= 16'd720;
      tick_interval <= 32'd50000;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        CFG_WIDTH:    panel_width   <= pwdata[15:0];
        CFG_HEIGHT:   panel_height  <= pwdata[15:0];
        CFG_INTERVAL: tick_interval <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_WIDTH:    prdata = {16'd0, panel_width};
      CFG_HEIGHT:   prdata = {16'd0, panel_height};
      CFG_INTERVAL: prdata = tick_interval;
      default:      prdata = 32'd0;
    endcase
  end

  grvp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  grvp_datapath #(
    .REGISTER_WORDS (REGISTER_WORDS),
    .MAX_CATCH_UP   (MAX_CATCH_UP)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .panel_width   (panel_width),
    .panel_height  (panel_height),
    .tick_interval (tick_interval),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule
